// ----- design/ftcrc_pkg.sv -----
// Package for the fragment tiler: shared constants, register indexes and the CRC-32 byte step.
// No dependencies; the interfaces and the top level use it.
package ftcrc_pkg;

    // Configuration port widths and register indexes.
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_BYTES   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TILES = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BITS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LORAWAN_MODE = 8'd3;

    // Register reset values.
    localparam logic [7:0]  RST_TILE_BYTES   = 8'd10;
    localparam logic [7:0]  RST_WINDOW_TILES = 8'd63;
    localparam logic [1:0]  RST_WINDOW_BITS  = 2'd2;
    localparam logic        RST_LORAWAN_MODE = 1'b1;
    localparam logic [15:0] RST_PER_WINDOW   = 16'd630;

    // Field widths.
    localparam int unsigned TILES_W = 16;
    localparam int unsigned CAP_W   = 19;

    localparam logic [TILES_W-1:0] TILES_SAT = '1;

    // Reflected CRC-32.
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

    // Advance the CRC over one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/ftcrc_ifs.sv -----
// Channel interfaces for the fragment tiler: byte input, result output, configuration writes.
// Depends on ftcrc_pkg for the configuration port widths.
interface ftcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ftcrc_out_if;
    logic        valid;
    logic        ready;
    logic        fits;
    logic [15:0] full_tiles;
    logic [7:0]  final_tile_bytes;
    logic [2:0]  window_count;
    logic [31:0] packet_crc;

    modport source (output valid, output fits, output full_tiles, output final_tile_bytes,
                    output window_count, output packet_crc, input ready);
    modport sink   (input valid, input fits, input full_tiles, input final_tile_bytes,
                    input window_count, input packet_crc, output ready);
endinterface

interface ftcrc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ftcrc_pkg::CFG_IDX_W-1:0]     reg_index;
    logic [ftcrc_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- design/fragment_tiler_with_crc32.sv -----
// Fragment tiler with CRC-32: per-packet byte, tile and window accounting plus packet CRC.
// Depends on ftcrc_pkg and the channel interfaces in ftcrc_ifs.sv.
//
//  channel  | dir | transfer                          | payload
//  ---------+-----+-----------------------------------+---------------------------------------
//  i_cfg    | in  | i_cfg.valid & i_cfg.ready         | reg_index, wdata
//  i_data   | in  | i_data.valid & i_data.ready       | data_byte, last_byte
//  o_res    | out | o_res.valid & o_res.ready         | fits, full_tiles, final_tile_bytes,
//           |     |                                   | window_count, packet_crc
//
// One byte is taken every cycle unless stalled; in LoRaWAN mode the counters and an 8-bit
// unrolled CRC update in one step. Results pass the packet stage, then the result register.
// i_cfg is always ready; the tile-per-window product is registered on the write itself.
// i_data stalls only while both the packet stage and the result register are full and
// o_res.ready is low. Reset (synchronous) clears the packet state and both valid flags.
module fragment_tiler_with_crc32 #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ftcrc_cfg_if.sink          i_cfg,
    ftcrc_in_if.sink           i_data,
    ftcrc_out_if.source        o_res
);

    localparam int unsigned        BT_W   = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [BT_W-1:0]    BT_SAT = BT_W'(MAX_PACKET_BYTES + 1);
    localparam logic [BT_W-1:0]    BT_MAX = BT_W'(MAX_PACKET_BYTES);

    // Configuration registers.
    logic [7:0]  r_tile_bytes;
    logic [7:0]  r_window_tiles;
    logic [1:0]  r_window_bits;
    logic        r_lorawan;
    logic [15:0] r_per_window;

    // Running packet state.
    logic [BT_W-1:0]               r_total;
    logic [7:0]                    r_off;
    logic [ftcrc_pkg::TILES_W-1:0] r_tiles;
    logic [31:0]                   r_crc;

    // Packet stage: state as it stood after the final byte.
    logic                          r_s1_valid;
    logic [BT_W-1:0]               r_s1_total;
    logic [7:0]                    r_s1_off;
    logic [ftcrc_pkg::TILES_W-1:0] r_s1_tiles;
    logic [31:0]                   r_s1_crc;

    // Result register.
    logic        r_out_valid;
    logic        r_out_fits;
    logic [15:0] r_out_full;
    logic [7:0]  r_out_final;
    logic [2:0]  r_out_windows;
    logic [31:0] r_out_crc;

    logic                          cfg_xfer;
    logic                          in_xfer;
    logic                          s1_move;
    logic [BT_W-1:0]               n_total;
    logic [7:0]                    off_inc;
    logic                          tile_wrap;
    logic [7:0]                    n_off;
    logic [ftcrc_pkg::TILES_W-1:0] n_tiles;
    logic [31:0]                   n_crc;

    logic [ftcrc_pkg::CAP_W-1:0]   size_ext;
    logic [ftcrc_pkg::CAP_W-1:0]   pw1;
    logic [ftcrc_pkg::CAP_W-1:0]   pw2;
    logic [ftcrc_pkg::CAP_W-1:0]   pw3;
    logic [ftcrc_pkg::CAP_W-1:0]   capacity;
    logic                          fits;
    logic [15:0]                   n_full;
    logic [7:0]                    n_final;
    logic [2:0]                    n_windows;

    // Handshakes.
    assign cfg_xfer     = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready  = 1'b1;
    assign s1_move      = r_s1_valid & (~r_out_valid | o_res.ready);
    assign i_data.ready = ~r_s1_valid | s1_move;
    assign in_xfer      = i_data.valid & i_data.ready;

    // Advance counters and CRC by one byte.
    always_comb begin
        n_total   = (r_total < BT_SAT) ? r_total + BT_W'(1) : r_total;
        off_inc   = r_off + 8'd1;
        tile_wrap = (off_inc >= r_tile_bytes);
        n_off     = tile_wrap ? 8'd0 : off_inc;
        n_tiles   = (tile_wrap && r_tiles != ftcrc_pkg::TILES_SAT)
                    ? r_tiles + ftcrc_pkg::TILES_W'(1) : r_tiles;
        n_crc     = ftcrc_pkg::crc_byte(r_crc, i_data.data_byte);
    end

    // Fit check, tiling and window count from the packet stage.
    always_comb begin
        size_ext = ftcrc_pkg::CAP_W'(r_s1_total);
        pw1      = ftcrc_pkg::CAP_W'(r_per_window);
        pw2      = pw1 << 1;
        pw3      = pw1 + pw2;
        capacity = pw1 << r_window_bits;
        fits     = (r_s1_total <= BT_MAX) && (size_ext <= capacity);

        if (r_s1_off == 8'd0) begin
            n_full  = (r_s1_tiles != '0) ? r_s1_tiles - 16'd1 : 16'd0;
            n_final = r_tile_bytes;
        end else begin
            n_full  = r_s1_tiles;
            n_final = r_s1_off;
        end

        if (size_ext > pw3) begin
            n_windows = 3'd4;
        end else if (size_ext > pw2) begin
            n_windows = 3'd3;
        end else if (size_ext > pw1) begin
            n_windows = 3'd2;
        end else begin
            n_windows = 3'd1;
        end
    end

    // Configuration writes; refresh the per-window product alongside.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_bytes   <= ftcrc_pkg::RST_TILE_BYTES;
            r_window_tiles <= ftcrc_pkg::RST_WINDOW_TILES;
            r_window_bits  <= ftcrc_pkg::RST_WINDOW_BITS;
            r_lorawan      <= ftcrc_pkg::RST_LORAWAN_MODE;
            r_per_window   <= ftcrc_pkg::RST_PER_WINDOW;
        end else if (cfg_xfer) begin
            unique case (i_cfg.reg_index)
                ftcrc_pkg::REG_TILE_BYTES: begin
                    r_tile_bytes <= i_cfg.wdata;
                    r_per_window <= 16'(i_cfg.wdata) * 16'(r_window_tiles);
                end
                ftcrc_pkg::REG_WINDOW_TILES: begin
                    r_window_tiles <= i_cfg.wdata;
                    r_per_window   <= 16'(r_tile_bytes) * 16'(i_cfg.wdata);
                end
                ftcrc_pkg::REG_WINDOW_BITS: begin
                    r_window_bits <= i_cfg.wdata[1:0];
                end
                ftcrc_pkg::REG_LORAWAN_MODE: begin
                    r_lorawan <= i_cfg.wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Packet state: advance on each byte in LoRaWAN mode, clear after the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_off   <= '0;
            r_tiles <= '0;
            r_crc   <= ftcrc_pkg::CRC_ALL_ONES;
        end else if (in_xfer) begin
            if (i_data.last_byte) begin
                r_total <= '0;
                r_off   <= '0;
                r_tiles <= '0;
                r_crc   <= ftcrc_pkg::CRC_ALL_ONES;
            end else if (r_lorawan) begin
                r_total <= n_total;
                r_off   <= n_off;
                r_tiles <= n_tiles;
                r_crc   <= n_crc;
            end
        end
    end

    // Packet stage: capture the final state of an enabled packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer && r_lorawan && i_data.last_byte) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_s1_total <= n_total;
            r_s1_off   <= n_off;
            r_s1_tiles <= n_tiles;
            r_s1_crc   <= n_crc;
        end
    end

    // Result register: load from the packet stage, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_move) begin
            r_out_fits    <= fits;
            r_out_full    <= fits ? n_full : 16'd0;
            r_out_final   <= fits ? n_final : 8'd0;
            r_out_windows <= fits ? n_windows : 3'd0;
            r_out_crc     <= fits ? (r_s1_crc ^ ftcrc_pkg::CRC_ALL_ONES) : 32'd0;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.fits             = r_out_fits;
    assign o_res.full_tiles       = r_out_full;
    assign o_res.final_tile_bytes = r_out_final;
    assign o_res.window_count     = r_out_windows;
    assign o_res.packet_crc       = r_out_crc;

endmodule

// ----- design/ftcrc_checker.sv -----
// Port-level checks for the fragment tiler, bound to the top level.
// Depends on the top level's port names only.
module ftcrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_fits,
    input logic [15:0] i_res_full_tiles,
    input logic [7:0]  i_res_final_tile_bytes,
    input logic [2:0]  i_res_window_count,
    input logic [31:0] i_res_packet_crc
);

    // No result straight out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid in the cycle after reset");

    // An oversized packet carries only zero fields.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_fits) |->
        (i_res_full_tiles == 16'd0 && i_res_final_tile_bytes == 8'd0 &&
         i_res_window_count == 3'd0 && i_res_packet_crc == 32'd0))
        else $error("rejected packet with non-zero fields");

    // An accepted packet needs one to four windows and a non-empty last tile.
    a_accept_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_fits) |->
        (i_res_window_count >= 3'd1 && i_res_window_count <= 3'd4 &&
         i_res_final_tile_bytes != 8'd0))
        else $error("accepted packet with bad window count or last tile size");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        (i_res_valid && $stable(i_res_fits) && $stable(i_res_full_tiles) &&
         $stable(i_res_final_tile_bytes) && $stable(i_res_window_count) &&
         $stable(i_res_packet_crc)))
        else $error("stalled result changed");

endmodule

bind fragment_tiler_with_crc32 ftcrc_checker u_ftcrc_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_res_valid            (o_res.valid),
    .i_res_ready            (o_res.ready),
    .i_res_fits             (o_res.fits),
    .i_res_full_tiles       (o_res.full_tiles),
    .i_res_final_tile_bytes (o_res.final_tile_bytes),
    .i_res_window_count     (o_res.window_count),
    .i_res_packet_crc       (o_res.packet_crc)
);
